@@ rtl/core/srkt_pkg.sv @@
// ----------------------------------------------------------------------------
// srkt_pkg: shared types and constants of the sorted ring key table.
// Holds the transaction payload types, the operation and status codes
// and the table dimensions.
// ----------------------------------------------------------------------------
package srkt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 16;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [6:0]       entry_count;
        logic [KEY_W-1:0] pred_key;
        logic [KEY_W-1:0] succ_key;
        logic [KEY_W-1:0] pred_pred_key;
        logic [KEY_W-1:0] succ_succ_key;
    } rsp_t;

endpackage

@@ rtl/core/srkt_ram.sv @@
// ----------------------------------------------------------------------------
// srkt_ram: simple dual-port synchronous RAM.
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module srkt_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/sorted_ring_key_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_ring_key_table_core: sorted ring table of unique 16-bit keys.
// Insert, delete and neighbor lookup on keys held in one RAM.
// ----------------------------------------------------------------------------
// The block holds up to CAPACITY unique keys in ascending order in one
// synchronous RAM and takes one transaction at a time. Every read goes
// through the one RAM read port: a transaction first reads keys from
// position 0 upward until it finds the position p of its key, then for an
// insert moves each key from p upward up one place, for a delete moves
// each key above p down one place, and then fetches up to four ring
// neighbors, one read each, before it waits for the output register to
// free up. A lookup that misses ends right after the search with no
// neighbor fetch. The result is held in an output register, and the
// table starts empty after reset with no clearing pass.
module sorted_ring_key_table_core
    import srkt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_DECIDE, S_INS_RD, S_INS_WR,
        S_DEL_RD, S_DEL_WR, S_NB_RD, S_NB_CAP, S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             found_reg, found_next;
    logic [2:0]       slot_reg, slot_next;
    logic [1:0]       status_reg, status_next;
    logic [KEY_W-1:0] nb_reg [4];
    logic [KEY_W-1:0] nb_next [4];
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [KEY_W-1:0] rd_data;

    logic             is_delete;
    logic             slot_used;
    logic signed [2:0] slot_ofs;
    logic [CNT_W-1:0] idx_inc;

    // Position p moved by d around a ring of n entries.
    function automatic logic [IDX_W-1:0] ring_pos(
        input logic [CNT_W-1:0] p,
        input logic signed [2:0] d,
        input logic [CNT_W-1:0] n
    );
        logic signed [CNT_W+1:0] v;
        logic signed [CNT_W+1:0] ns;
        ns = $signed({2'b00, n});
        v  = $signed({2'b00, p}) + $signed({{(CNT_W-1){d[2]}}, d});
        if (v < 0)
        begin
            v = v + ns;
        end
        if (v < 0)
        begin
            v = v + ns;
        end
        if (v >= ns)
        begin
            v = v - ns;
        end
        if (v >= ns)
        begin
            v = v - ns;
        end
        return v[IDX_W-1:0];
    endfunction

    srkt_ram #(
        .DATA_W (KEY_W),
        .DEPTH  (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign is_delete = (op_reg == FUNC_DELETE);
    assign idx_inc   = idx_reg + 1'b1;

    // Neighbor slot selection: 0 pred, 1 succ, 2 pred-pred, 3 succ-succ.
    always_comb
    begin
        case (slot_reg)
            3'd0:
            begin
                slot_ofs  = -3'sd1;
                slot_used = is_delete ? (count_reg >= CNT_W'(1))
                                      : (count_reg >= CNT_W'(2));
            end
            3'd1:
            begin
                slot_ofs  = is_delete ? 3'sd0 : 3'sd1;
                slot_used = is_delete ? (count_reg >= CNT_W'(1))
                                      : (count_reg >= CNT_W'(2));
            end
            3'd2:
            begin
                slot_ofs  = -3'sd2;
                slot_used = (count_reg >= CNT_W'(2));
            end
            3'd3:
            begin
                slot_ofs  = is_delete ? 3'sd1 : 3'sd2;
                slot_used = (count_reg >= CNT_W'(2));
            end
            default:
            begin
                slot_ofs  = 3'sd0;
                slot_used = 1'b0;
            end
        endcase
    end

    // Sequencer: search, shift, neighbor fetch, result.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        nb_next        = nb_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IDX_W-1:0];
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = (req.func == FUNC_INSERT || req.func == FUNC_DELETE)
                                  ? req.func : FUNC_LOOKUP;
                    key_next    = req.key;
                    idx_next    = '0;
                    status_next = ST_DONE;
                    for (int i = 0; i < 4; i++)
                    begin
                        nb_next[i] = '0;
                    end
                    state_next  = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    pos_next   = idx_reg;
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (rd_data >= key_reg)
                begin
                    pos_next   = idx_reg;
                    found_next = (rd_data == key_reg);
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SRCH_RD;
                end
            end
            S_DECIDE:
            begin
                slot_next = '0;
                case (op_reg)
                    FUNC_INSERT:
                    begin
                        if (found_reg)
                        begin
                            status_next = ST_DUP;
                            state_next  = S_DONE;
                        end
                        else if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_NOTFOUND;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            idx_next   = pos_reg;
                            state_next = S_DEL_RD;
                        end
                    end
                    default:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_NOTFOUND;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_NB_RD;
                        end
                    end
                endcase
            end
            // Shift keys up one place, top first, then drop the new key in.
            S_INS_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = key_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_NB_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(idx_reg - 1'b1);
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_reg - 1'b1;
                state_next = S_INS_RD;
            end
            // Shift keys above the deleted one down one place.
            S_DEL_RD:
            begin
                if (idx_inc == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_NB_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[IDX_W-1:0];
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_inc;
                state_next = S_DEL_RD;
            end
            // Fetch up to four ring neighbors one read at a time.
            S_NB_RD:
            begin
                if (slot_reg == 3'd4)
                begin
                    state_next = S_DONE;
                end
                else if (!slot_used)
                begin
                    slot_next = slot_reg + 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ring_pos(pos_reg, slot_ofs, count_reg);
                    state_next = S_NB_CAP;
                end
            end
            S_NB_CAP:
            begin
                nb_next[slot_reg[1:0]] = rd_data;
                slot_next  = slot_reg + 1'b1;
                state_next = S_NB_RD;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.entry_count   = 7'(count_reg);
                    rsp_next.pred_key      = nb_reg[0];
                    rsp_next.succ_key      = nb_reg[1];
                    rsp_next.pred_pred_key = nb_reg[2];
                    rsp_next.succ_succ_key = nb_reg[3];
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        nb_reg     <= nb_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The key count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    // The key count moves by at most one per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("key count jumped");

    // An accepted transaction leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_SRCH_RD))
        else $error("accepted transaction not started");

    // A new result is only loaded from the result state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside result state");

endmodule
